// File: rtl/swe_pkg.sv
// ----------------------------------------------------------------------------
// swe_pkg
// Shared types and constants for the sliding window extreme block: cell
// entry, per-cycle cell control and register indexes.
// ----------------------------------------------------------------------------
package swe_pkg;

  localparam int WINDOW_MAX    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int POS_W         = 32;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int AGE_W         = $clog2(WINDOW_MAX);
  localparam int SUFFIX_LEVELS = $clog2(WINDOW_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_SELECT_MIN    = 2'd1
  } cfg_reg_e;

  // one deque entry held by a cell; age counts samples since it was appended
  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [AGE_W-1:0]              age;
  } entry_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic                          step;
    logic                          shift;
    logic                          select_min;
    logic signed [SAMPLE_BITS-1:0] fresh;
  } cell_ctl_t;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, value: '0, age: '0};

endpackage

// File: rtl/swe_cell.sv
// ----------------------------------------------------------------------------
// swe_cell
// One deque slot. Takes its right neighbor's entry when the front advances,
// drops itself when beaten as part of the back suffix, and takes the new
// sample when it is the first free slot.
// ----------------------------------------------------------------------------
module swe_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swe_pkg::cell_ctl_t ctl_i,
  input  swe_pkg::entry_t    right_i,
  input  logic               left_kept_i,
  input  logic               suffix_i,
  output swe_pkg::entry_t    entry_o,
  output logic               cut_o,
  output logic               kept_o
);
  import swe_pkg::*;

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic [AGE_W-1:0]              age_q, age_d;
  entry_t                        shifted;
  logic                          beaten;
  logic                          slot_free;

  assign entry_o = '{valid: valid_q, value: value_q, age: age_q};

  always_comb begin
    shifted = ctl_i.shift ? right_i : entry_o;
    if (ctl_i.select_min) begin
      beaten = $signed(ctl_i.fresh) < $signed(shifted.value);
    end else begin
      beaten = $signed(ctl_i.fresh) > $signed(shifted.value);
    end
    cut_o     = !shifted.valid || beaten;
    kept_o    = shifted.valid && !suffix_i;
    slot_free = !kept_o && left_kept_i;
  end

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    age_d   = age_q;
    if (ctl_i.step) begin
      if (kept_o) begin
        valid_d = 1'b1;
        value_d = shifted.value;
        age_d   = shifted.age + AGE_W'(1);
      end else if (slot_free) begin
        valid_d = 1'b1;
        value_d = ctl_i.fresh;
        age_d   = '0;
      end else begin
        valid_d = 1'b0;
        value_d = shifted.value;
        age_d   = shifted.age;
      end
    end else if (ctl_i.shift) begin
      valid_d = shifted.valid;
      value_d = shifted.value;
      age_d   = shifted.age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

endmodule

// File: rtl/swe_suffix_and.sv
// ----------------------------------------------------------------------------
// swe_suffix_and
// Log-depth suffix AND over the cell row: bit i is set when every cell from
// i to the end is empty or beaten by the new sample.
// ----------------------------------------------------------------------------
module swe_suffix_and (
  input  logic [swe_pkg::WINDOW_MAX-1:0] cut_i,
  output logic [swe_pkg::WINDOW_MAX-1:0] suffix_o
);
  import swe_pkg::*;

  logic [WINDOW_MAX-1:0] level [SUFFIX_LEVELS+1];

  assign level[0] = cut_i;

  for (genvar k = 0; k < SUFFIX_LEVELS; k++) begin : g_level
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_bit
      if (i + (1 << k) < WINDOW_MAX) begin : g_pair
        assign level[k+1][i] = level[k][i] & level[k][i + (1 << k)];
      end else begin : g_pass
        assign level[k+1][i] = level[k][i];
      end
    end
  end

  assign suffix_o = level[SUFFIX_LEVELS];

endmodule

// File: rtl/sliding_window_extreme.sv
// Latency: a request is accepted and its result is valid on the next cycle.
// Throughput: one request per cycle while the result side keeps up and no front trim is pending.
// After window_length is shortened, a waiting request trims the front with in_ready_o low,
// one expiring entry beyond the first per single-step shift, before the request is accepted.
// Reset empties the queue, clears the sample count, selects maximum mode and
// a window of 8 samples.
// ----------------------------------------------------------------------------
// sliding_window_extreme
// Running maximum or minimum over the most recent samples, kept as a
// monotonic deque in a row of cells with the front entry at cell 0.
// ----------------------------------------------------------------------------
module sliding_window_extreme (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swe_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [swe_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [swe_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [swe_pkg::SAMPLE_BITS-1:0] window_extreme_o,
  output logic [swe_pkg::POS_W-1:0]            extreme_position_o
);
  import swe_pkg::*;

  logic [CFG_W-1:0]      window_length_q;
  logic                  select_min_q;
  logic [POS_W-1:0]      sample_count_q, sample_count_d;
  logic                  out_valid_q, out_valid_d;
  logic [AGE_W-1:0]      len_m1;
  logic                  expire_front;
  logic                  room;
  logic                  trim;
  logic                  step;
  cell_ctl_t             ctl;
  entry_t                cells [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] cut, kept, suffix, valid_vec;

  // window length minus one, clamped to the supported range
  always_comb begin
    if (window_length_q == '0) begin
      len_m1 = '0;
    end else if (window_length_q > CFG_W'(WINDOW_MAX)) begin
      len_m1 = AGE_W'(WINDOW_MAX - 1);
    end else begin
      len_m1 = AGE_W'(window_length_q - CFG_W'(1));
    end
  end

  // trim only for a waiting request and never under a held result
  assign room         = !out_valid_q || out_ready_i;
  assign expire_front = cells[0].valid && (cells[0].age >= len_m1);
  assign trim         = in_valid_i && room && cells[1].valid && (cells[1].age >= len_m1);
  assign in_ready_o   = room && !trim;
  assign step         = in_valid_i && in_ready_o;

  assign ctl = '{step: step, shift: trim || (step && expire_front),
                 select_min: select_min_q, fresh: sample_i};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    entry_t right;
    logic   left_kept;
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right = EMPTY_ENTRY;
    end else begin : g_mid
      assign right = cells[i+1];
    end
    if (i == 0) begin : g_first
      assign left_kept = 1'b1;
    end else begin : g_rest
      assign left_kept = kept[i-1];
    end
    swe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .right_i     (right),
      .left_kept_i (left_kept),
      .suffix_i    (suffix[i]),
      .entry_o     (cells[i]),
      .cut_o       (cut[i]),
      .kept_o      (kept[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  swe_suffix_and u_suffix (
    .cut_i    (cut),
    .suffix_o (suffix)
  );

  always_comb begin
    sample_count_d = sample_count_q;
    out_valid_d    = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      sample_count_d = sample_count_q + POS_W'(1);
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= CFG_W'(8);
      select_min_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: window_length_q <= cfg_data_i;
        REG_SELECT_MIN:    select_min_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      sample_count_q <= sample_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // front entry is the result; its position follows from its age
  assign out_valid_o        = out_valid_q;
  assign window_extreme_o   = cells[0].value;
  assign extreme_position_o = sample_count_q - POS_W'(cells[0].age) - POS_W'(1);

`ifndef ASSERT_OFF
  a_front_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cells[0].valid)
    else $error("result shown with empty queue");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + WINDOW_MAX'(1)) & valid_vec) == '0)
    else $error("queue entries not contiguous from the front");

  a_front_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (cells[0].age <= $past(len_m1)))
    else $error("front entry outside the window after a request");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o && (sample_count_q == $past(sample_count_q) + POS_W'(1)))
    else $error("request without result or count update");

  a_trim_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trim |=> $stable(sample_count_q))
    else $error("sample count moved during front trim");
`endif

endmodule
